>>> hdl/cpd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the polyline densifier
package cpd_pkg;
  localparam int COORD_BITS = 12;
  localparam int MAX_INSERT = 31;
  localparam int CNT_BITS = 6;  // holds MAX_INSERT + 1
  localparam int SPC_BITS = 13;
  localparam logic [SPC_BITS-1:0] SPACING_RESET = 13'd2560;
  localparam int Q_DEPTH = 2;

  // one segment job handed from front to back
  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
    logic                  has_seg;   // segment precedes the vertex
    logic                  emit_vtx;  // vertex b is emitted after the points
    logic                  last;      // last job of the item
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COUNT, ST_DIV, ST_EMIT, ST_VTX
  } st_t;
endpackage

>>> hdl/cpd_front.sv
`timescale 1ns / 1ps
// front: takes vertices, tracks contour state, issues segment jobs
module cpd_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cpd_pkg::COORD_BITS-1:0] in_x,
  input  logic [cpd_pkg::COORD_BITS-1:0] in_y,
  input  logic                           in_is_first,
  input  logic                           in_is_final,
  output logic                           job_valid,
  input  logic                           job_ready,
  output cpd_pkg::job_t                  job
);
  logic [cpd_pkg::COORD_BITS-1:0] prev_x_r, prev_y_r, start_x_r, start_y_r;
  logic [cpd_pkg::COORD_BITS-1:0] prev_x_nxt, prev_y_nxt, start_x_nxt, start_y_nxt;
  logic open_r, open_nxt;
  logic close_r, close_nxt;  // closing job still to issue
  logic new_c;

  assign new_c = in_is_first || !open_r;
  assign in_ready = job_ready && !close_r;

  always_comb begin
    job_valid = close_r || in_valid;
    job.ax = prev_x_r;
    job.ay = prev_y_r;
    job.bx = in_x;
    job.by = in_y;
    job.has_seg = !new_c;
    job.emit_vtx = 1'b1;
    job.last = !in_is_final;
    if (close_r) begin
      job.bx = start_x_r;
      job.by = start_y_r;
      job.has_seg = 1'b1;
      job.emit_vtx = 1'b0;
      job.last = 1'b1;
    end
  end

  always_comb begin
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    open_nxt = open_r;
    close_nxt = close_r;
    if (close_r && job_ready) begin
      close_nxt = 1'b0;
    end else if (in_valid && in_ready) begin
      prev_x_nxt = in_x;
      prev_y_nxt = in_y;
      if (new_c) begin
        start_x_nxt = in_x;
        start_y_nxt = in_y;
      end
      open_nxt = !in_is_final;
      close_nxt = in_is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      open_r <= 1'b0;
      close_r <= 1'b0;
    end else begin
      prev_x_r <= prev_x_nxt;
      prev_y_r <= prev_y_nxt;
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
      open_r <= open_nxt;
      close_r <= close_nxt;
    end
  end
endmodule

>>> hdl/cpd_queue.sv
`timescale 1ns / 1ps
// short job queue between front and back
module cpd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  cpd_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output cpd_pkg::job_t rd_job
);
  cpd_pkg::job_t mem_r [cpd_pkg::Q_DEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'(cpd_pkg::Q_DEPTH);
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

>>> hdl/cpd_back.sv
`timescale 1ns / 1ps
// back: counts inserts, divides per point, emits results
module cpd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [cpd_pkg::SPC_BITS-1:0]   spacing,
  input  logic                           job_valid,
  output logic                           job_ready,
  input  cpd_pkg::job_t                  job,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cpd_pkg::COORD_BITS-1:0] out_x,
  output logic [cpd_pkg::COORD_BITS-1:0] out_y,
  output logic                           out_inserted,
  output logic                           out_clipped,
  output logic                           out_run_end
);
  localparam int CB = cpd_pkg::COORD_BITS;
  localparam int NB = CB + cpd_pkg::CNT_BITS;  // k*mag width
  localparam int DB = cpd_pkg::CNT_BITS;       // divisor width
  localparam int SQB = 2 * CB + 1 + 16;        // rhs width
  localparam int TB = cpd_pkg::SPC_BITS + cpd_pkg::CNT_BITS;

  cpd_pkg::st_t st_r, st_nxt;
  cpd_pkg::job_t job_r;
  logic [SQB-1:0] rhs_r;
  logic [TB-1:0] t_r;          // k*spacing
  logic [cpd_pkg::CNT_BITS-1:0] k_r, n_r;
  logic clip_r;
  logic [CB-1:0] mx_r, my_r;
  logic nx_r, ny_r;
  // restoring divider, both axes together
  logic [NB-1:0] qx_r, qy_r;
  logic [DB:0] rx_r, ry_r;
  logic [$clog2(NB+1)-1:0] bit_r;
  // final vertex parked in the output register until the closing count is known
  logic hold_r, hold_nxt;
  logic out_valid_nxt;

  logic [CB-1:0] dxa, dya;
  logic [DB-1:0] m;
  logic [2*TB-1:0] tsq;
  logic over;
  logic [NB-1:0] numx, numy;
  logic [$clog2(NB)-1:0] bidx;
  logic [DB:0] rxs, rys;
  logic div_done;
  logic [CB-1:0] px, py;
  logic sent;

  assign dxa = job.ax > job.bx ? job.ax - job.bx : job.bx - job.ax;
  assign dya = job.ay > job.by ? job.ay - job.by : job.by - job.ay;
  assign m = n_r + 1'b1;
  assign tsq = t_r * t_r;
  assign over = SQB'(tsq) > rhs_r;
  assign numx = NB'(k_r) * NB'(mx_r);
  assign numy = NB'(k_r) * NB'(my_r);
  assign bidx = bit_r[$clog2(NB)-1:0] - 1'b1;
  assign rxs = {rx_r[DB-1:0], numx[bidx]};
  assign rys = {ry_r[DB-1:0], numy[bidx]};
  assign div_done = bit_r == '0;
  assign sent = !out_valid || out_ready;

  // rounding of the finished quotient, then the signed offset from the start point
  function automatic logic [CB-1:0] fin_axis(input logic [CB-1:0] a, input logic neg,
      input logic [NB-1:0] q, input logic [DB:0] r, input logic [DB-1:0] d);
    logic [NB-1:0] qq;
    logic [DB+1:0] r2;
    r2 = {r, 1'b0};
    qq = q;
    if (r2 > (DB+2)'(d) || (r2 == (DB+2)'(d) && q[0])) qq = q + 1'b1;
    fin_axis = neg ? a - CB'(qq) : a + CB'(qq);
  endfunction

  assign px = fin_axis(job_r.ax, nx_r, qx_r, rx_r, m);
  assign py = fin_axis(job_r.ay, ny_r, qy_r, ry_r, m);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      cpd_pkg::ST_IDLE:
        if (job_valid) st_nxt = job.has_seg ? cpd_pkg::ST_COUNT : cpd_pkg::ST_VTX;
      cpd_pkg::ST_COUNT:
        if (k_r == cpd_pkg::CNT_BITS'(cpd_pkg::MAX_INSERT + 1) || over) begin
          st_nxt = (n_r == '0) ? (job_r.emit_vtx ? cpd_pkg::ST_VTX : cpd_pkg::ST_IDLE)
                                : cpd_pkg::ST_DIV;
        end
      cpd_pkg::ST_DIV:
        if (div_done) st_nxt = cpd_pkg::ST_EMIT;
      cpd_pkg::ST_EMIT:
        if (sent) begin
          if (k_r != n_r) st_nxt = cpd_pkg::ST_DIV;
          else st_nxt = job_r.emit_vtx ? cpd_pkg::ST_VTX : cpd_pkg::ST_IDLE;
        end
      cpd_pkg::ST_VTX:
        if (sent) st_nxt = cpd_pkg::ST_IDLE;
      default: st_nxt = cpd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready = st_r == cpd_pkg::ST_IDLE;
  end

  always_comb begin
    out_valid_nxt = out_valid;
    hold_nxt = hold_r;
    if (out_valid && out_ready) out_valid_nxt = 1'b0;
    if ((st_r == cpd_pkg::ST_EMIT || (st_r == cpd_pkg::ST_VTX && job_r.last)) && sent) begin
      out_valid_nxt = 1'b1;
    end
    if (st_r == cpd_pkg::ST_VTX && !job_r.last && sent) hold_nxt = 1'b1;
    // closing count done: release the parked vertex
    if (st_r == cpd_pkg::ST_COUNT && st_nxt != cpd_pkg::ST_COUNT && hold_r) begin
      out_valid_nxt = 1'b1;
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= cpd_pkg::ST_IDLE;
      out_valid <= 1'b0;
      hold_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= out_valid_nxt;
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      cpd_pkg::ST_IDLE: begin
        job_r <= job;
        rhs_r <= {SQB'(dxa) * SQB'(dxa) + SQB'(dya) * SQB'(dya)} << 16;
        t_r <= TB'(spacing);
        k_r <= cpd_pkg::CNT_BITS'(1);
        n_r <= '0;
        clip_r <= 1'b0;
        mx_r <= dxa;
        my_r <= dya;
        nx_r <= job.bx < job.ax;
        ny_r <= job.by < job.ay;
      end
      cpd_pkg::ST_COUNT: begin
        if (!(k_r == cpd_pkg::CNT_BITS'(cpd_pkg::MAX_INSERT + 1) || over)) begin
          n_r <= k_r;
          k_r <= k_r + 1'b1;
          t_r <= t_r + TB'(spacing);
        end else begin
          if (!over) begin
            n_r <= cpd_pkg::CNT_BITS'(cpd_pkg::MAX_INSERT);
            clip_r <= 1'b1;
          end
          // closing segment without inserts: the parked vertex ends the item
          if (hold_r && n_r == '0) out_run_end <= 1'b1;
          k_r <= cpd_pkg::CNT_BITS'(1);
          bit_r <= ($clog2(NB+1))'(NB);
          rx_r <= '0;
          ry_r <= '0;
        end
      end
      cpd_pkg::ST_DIV: begin
        if (!div_done) begin
          bit_r <= bit_r - 1'b1;
          rx_r <= rxs >= (DB+1)'(m) ? rxs - (DB+1)'(m) : rxs;
          ry_r <= rys >= (DB+1)'(m) ? rys - (DB+1)'(m) : rys;
          qx_r <= {qx_r[NB-2:0], rxs >= (DB+1)'(m)};
          qy_r <= {qy_r[NB-2:0], rys >= (DB+1)'(m)};
        end
      end
      cpd_pkg::ST_EMIT: begin
        if (sent) begin
          out_x <= px;
          out_y <= py;
          out_inserted <= 1'b1;
          out_clipped <= clip_r;
          out_run_end <= job_r.last && !job_r.emit_vtx && k_r == n_r;
          k_r <= k_r + 1'b1;
          bit_r <= ($clog2(NB+1))'(NB);
          rx_r <= '0;
          ry_r <= '0;
        end
      end
      cpd_pkg::ST_VTX: begin
        if (sent) begin
          out_x <= job_r.bx;
          out_y <= job_r.by;
          out_inserted <= 1'b0;
          out_clipped <= clip_r;
          out_run_end <= job_r.last;
        end
      end
      default: ;
    endcase
  end
endmodule

>>> hdl/closed_polyline_densifier.sv
`timescale 1ns / 1ps
// top level of the closed polyline densifier
// usage:
//  - in_ channel carries one vertex per item with first and final marks
//  - out_ channel carries emitted points; run_end marks the last point of an item
//  - cfg_we writes min_spacing (Q8 pixels); user's duty: only while the block is idle, unenforced
// structure: a front tracks the contour and turns each vertex into segment jobs
//  (one, or two on a final vertex), a two-entry queue decouples it from the
//  back, which counts inserts and emits the points through an output register
// timing:
//  - insert count: one compare a cycle per segment
//  - each inserted point: a bit-serial divide of both axes, then the emit
// reset: contour state cleared, no contour open, spacing back to 10 pixels
// stall: a stalled receiver holds the output register, the back waits and
//  the queue then fills, after which in_ready drops
// note: a final vertex is parked in the output register until the closing
//  segment is counted; with no inserts on that segment it carries run_end
module closed_polyline_densifier (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cpd_pkg::SPC_BITS-1:0]   cfg_min_spacing,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cpd_pkg::COORD_BITS-1:0] in_x,
  input  logic [cpd_pkg::COORD_BITS-1:0] in_y,
  input  logic                           in_is_first,
  input  logic                           in_is_final,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cpd_pkg::COORD_BITS-1:0] out_x,
  output logic [cpd_pkg::COORD_BITS-1:0] out_y,
  output logic                           out_inserted,
  output logic                           out_clipped,
  output logic                           out_run_end
);
  logic [cpd_pkg::SPC_BITS-1:0] spacing_r;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  cpd_pkg::job_t fjob, bjob;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= cpd_pkg::SPACING_RESET;
    end else if (cfg_we) begin
      spacing_r <= cfg_min_spacing;
    end
  end

  cpd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_x, .in_y, .in_is_first, .in_is_final,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fjob)
  );

  cpd_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fjob),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bjob)
  );

  cpd_back u_back (
    .clk, .rst_n, .spacing(spacing_r), .job_valid(bj_valid), .job_ready(bj_ready),
    .job(bjob), .out_valid, .out_ready, .out_x, .out_y, .out_inserted, .out_clipped,
    .out_run_end
  );
endmodule

>>> hdl/cpd_checker.sv
`timescale 1ns / 1ps
// port checker for the densifier, bound to the top level
module cpd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [cpd_pkg::COORD_BITS-1:0] out_x,
  input logic [cpd_pkg::COORD_BITS-1:0] out_y,
  input logic                           out_inserted,
  input logic                           out_clipped,
  input logic                           out_run_end
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable({out_x, out_y, out_inserted, out_clipped, out_run_end}))
    else $error("out changed");
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid) else $error("in dropped");
endmodule

bind closed_polyline_densifier cpd_checker u_cpd_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_x, .out_y,
  .out_inserted, .out_clipped, .out_run_end
);
